FILE: hw/rtl/wav_header_stream_parser_top_macros.svh
// Assertion macros shared by the parser RTL.
`ifndef WAV_HEADER_STREAM_PARSER_TOP_MACROS_SVH
`define WAV_HEADER_STREAM_PARSER_TOP_MACROS_SVH

// The expression holds at every clock edge out of reset.
`define WAVHP_ASSERT_HOLDS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("wavhp invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define WAVHP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wavhp implication violated");

// The consequent holds in the cycle after the antecedent.
`define WAVHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wavhp next-cycle check violated");

`endif

FILE: hw/rtl/wavhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wavhp_pkg;

  typedef enum logic [3:0] {
    PH_RIFF       = 4'd0,
    PH_FMT_ID     = 4'd1,
    PH_SKIP1_SIZE = 4'd2,
    PH_SKIP1_BODY = 4'd3,
    PH_FMT_SIZE   = 4'd4,
    PH_FMT_BODY   = 4'd5,
    PH_FMT_PAD    = 4'd6,
    PH_DATA_ID    = 4'd7,
    PH_SKIP2_SIZE = 4'd8,
    PH_SKIP2_BODY = 4'd9,
    PH_DATA_SIZE  = 4'd10,
    PH_PAYLOAD    = 4'd11,
    PH_DONE       = 4'd12,
    PH_ERROR      = 4'd13
  } phase_t;

  typedef enum logic [1:0] {
    ST_HEADER    = 2'd0,
    ST_PAYLOAD   = 2'd1,
    ST_AFTER_END = 2'd2,
    ST_ERROR     = 2'd3
  } status_t;

  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [23:0] ID_FMT3 = 24'h74_6d66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  localparam logic [4:0] RIFF_HDR_LEN   = 5'd12;
  localparam logic [4:0] WORD_LEN       = 5'd4;
  localparam logic [4:0] FMT_FIELDS_LEN = 5'd16;
  localparam logic [4:0] CHAN_OFS       = 5'd2;
  localparam logic [4:0] RATE_END_OFS   = 5'd7;
  localparam logic [4:0] BITS_OFS       = 5'd14;

  localparam logic [31:0] FMT_FIELDS_BYTES = 32'd16;

  typedef struct packed {
    status_t     status;
    logic [7:0]  payload_byte;
    logic        last_payload;
    logic [7:0]  channel_count;
    logic [31:0] rate_hz;
    logic [7:0]  sample_bits;
    logic [31:0] payload_length;
  } wavhp_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wavhp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wavhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source(output valid, output data_byte, output start_of_file, input ready);
  modport sink(input valid, input data_byte, input start_of_file, output ready);
endinterface

interface wavhp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  payload_byte;
  logic        last_payload;
  logic [7:0]  channel_count;
  logic [31:0] rate_hz;
  logic [7:0]  sample_bits;
  logic [31:0] payload_length;

  modport source(output valid, output status, output payload_byte, output last_payload,
                 output channel_count, output rate_hz, output sample_bits,
                 output payload_length, input ready);
  modport sink(input valid, input status, input payload_byte, input last_payload,
               input channel_count, input rate_hz, input sample_bits,
               input payload_length, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/wavhp_core.sv
`timescale 1ns / 1ps
`default_nettype none

`include "wav_header_stream_parser_top_macros.svh"

module wavhp_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step_en,
  input  logic [7:0]              data_byte,
  input  logic                    start_of_file,
  output wavhp_pkg::wavhp_result_t result
);

  wavhp_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [7:0]  chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [7:0]  bits_r, bits_nxt;
  logic [31:0] len_r, len_nxt;

  wavhp_pkg::phase_t phase_cur;
  logic [4:0]  idx_cur;
  logic [4:0]  idx_inc;
  logic [31:0] word_cur;
  logic [31:0] rem_cur;
  logic [31:0] rem_dec;
  logic [31:0] shifted;
  logic        word_done;

  // A start of file byte is parsed against the reset state.
  always_comb begin
    phase_cur = start_of_file ? wavhp_pkg::PH_RIFF : phase_r;
    idx_cur   = start_of_file ? 5'd0 : idx_r;
    word_cur  = start_of_file ? 32'd0 : word_r;
    rem_cur   = start_of_file ? 32'd0 : rem_r;
    chan_nxt  = start_of_file ? 8'd0 : chan_r;
    rate_nxt  = start_of_file ? 32'd0 : rate_r;
    bits_nxt  = start_of_file ? 8'd0 : bits_r;
    len_nxt   = start_of_file ? 32'd0 : len_r;

    shifted   = {data_byte, word_cur[31:8]};
    idx_inc   = idx_cur + 5'd1;
    rem_dec   = rem_cur - 32'd1;
    word_done = (idx_inc == wavhp_pkg::WORD_LEN);

    phase_nxt = phase_cur;
    idx_nxt   = idx_cur;
    word_nxt  = word_cur;
    rem_nxt   = rem_cur;

    result.status       = wavhp_pkg::ST_HEADER;
    result.payload_byte = 8'd0;
    result.last_payload = 1'b0;

    case (phase_cur)
      wavhp_pkg::PH_RIFF: begin
        word_nxt = shifted;
        idx_nxt  = idx_inc;
        if (idx_inc == wavhp_pkg::RIFF_HDR_LEN) begin
          idx_nxt   = 5'd0;
          phase_nxt = (shifted == wavhp_pkg::ID_WAVE) ? wavhp_pkg::PH_FMT_ID
                                                      : wavhp_pkg::PH_ERROR;
        end
      end
      wavhp_pkg::PH_FMT_ID: begin
        word_nxt = shifted;
        idx_nxt  = idx_inc;
        if (word_done) begin
          idx_nxt   = 5'd0;
          phase_nxt = (shifted[23:0] == wavhp_pkg::ID_FMT3) ? wavhp_pkg::PH_FMT_SIZE
                                                           : wavhp_pkg::PH_SKIP1_SIZE;
        end
      end
      wavhp_pkg::PH_SKIP1_SIZE, wavhp_pkg::PH_SKIP2_SIZE: begin
        word_nxt = shifted;
        idx_nxt  = idx_inc;
        if (word_done) begin
          idx_nxt = 5'd0;
          rem_nxt = shifted;
          if (phase_cur == wavhp_pkg::PH_SKIP1_SIZE) begin
            phase_nxt = (shifted == 32'd0) ? wavhp_pkg::PH_FMT_ID : wavhp_pkg::PH_SKIP1_BODY;
          end else begin
            phase_nxt = (shifted == 32'd0) ? wavhp_pkg::PH_DATA_ID : wavhp_pkg::PH_SKIP2_BODY;
          end
        end
      end
      wavhp_pkg::PH_SKIP1_BODY, wavhp_pkg::PH_SKIP2_BODY, wavhp_pkg::PH_FMT_PAD: begin
        rem_nxt = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_nxt = (phase_cur == wavhp_pkg::PH_SKIP1_BODY) ? wavhp_pkg::PH_FMT_ID
                                                              : wavhp_pkg::PH_DATA_ID;
        end
      end
      wavhp_pkg::PH_FMT_SIZE: begin
        word_nxt = shifted;
        idx_nxt  = idx_inc;
        if (word_done) begin
          idx_nxt   = 5'd0;
          rem_nxt   = shifted;
          phase_nxt = wavhp_pkg::PH_FMT_BODY;
        end
      end
      wavhp_pkg::PH_FMT_BODY: begin
        word_nxt = shifted;
        idx_nxt  = idx_inc;
        if (idx_cur == wavhp_pkg::CHAN_OFS) begin
          chan_nxt = data_byte;
        end
        if (idx_cur == wavhp_pkg::RATE_END_OFS) begin
          rate_nxt = shifted;
        end
        if (idx_cur == wavhp_pkg::BITS_OFS) begin
          bits_nxt = data_byte;
        end
        if (idx_inc == wavhp_pkg::FMT_FIELDS_LEN) begin
          idx_nxt = 5'd0;
          if (rem_cur > wavhp_pkg::FMT_FIELDS_BYTES) begin
            rem_nxt   = rem_cur - wavhp_pkg::FMT_FIELDS_BYTES;
            phase_nxt = wavhp_pkg::PH_FMT_PAD;
          end else begin
            rem_nxt   = 32'd0;
            phase_nxt = wavhp_pkg::PH_DATA_ID;
          end
        end
      end
      wavhp_pkg::PH_DATA_ID: begin
        word_nxt = shifted;
        idx_nxt  = idx_inc;
        if (word_done) begin
          idx_nxt   = 5'd0;
          phase_nxt = (shifted == wavhp_pkg::ID_DATA) ? wavhp_pkg::PH_DATA_SIZE
                                                      : wavhp_pkg::PH_SKIP2_SIZE;
        end
      end
      wavhp_pkg::PH_DATA_SIZE: begin
        word_nxt = shifted;
        idx_nxt  = idx_inc;
        if (word_done) begin
          idx_nxt   = 5'd0;
          len_nxt   = shifted;
          rem_nxt   = shifted;
          phase_nxt = (shifted == 32'd0) ? wavhp_pkg::PH_DONE : wavhp_pkg::PH_PAYLOAD;
        end
      end
      wavhp_pkg::PH_PAYLOAD: begin
        result.status       = wavhp_pkg::ST_PAYLOAD;
        result.payload_byte = data_byte;
        rem_nxt             = rem_dec;
        if (rem_dec == 32'd0) begin
          result.last_payload = 1'b1;
          phase_nxt           = wavhp_pkg::PH_DONE;
        end
      end
      wavhp_pkg::PH_DONE: begin
        result.status = wavhp_pkg::ST_AFTER_END;
      end
      default: begin
        phase_nxt = wavhp_pkg::PH_ERROR;
      end
    endcase

    // The error state is sticky until a start of file byte and masks every other status.
    if (phase_nxt == wavhp_pkg::PH_ERROR) begin
      result.status       = wavhp_pkg::ST_ERROR;
      result.payload_byte = 8'd0;
      result.last_payload = 1'b0;
    end

    result.channel_count  = chan_nxt;
    result.rate_hz        = rate_nxt;
    result.sample_bits    = bits_nxt;
    result.payload_length = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wavhp_pkg::PH_RIFF;
      idx_r   <= 5'd0;
      word_r  <= 32'd0;
      rem_r   <= 32'd0;
      chan_r  <= 8'd0;
      rate_r  <= 32'd0;
      bits_r  <= 8'd0;
      len_r   <= 32'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      word_r  <= word_nxt;
      rem_r   <= rem_nxt;
      chan_r  <= chan_nxt;
      rate_r  <= rate_nxt;
      bits_r  <= bits_nxt;
      len_r   <= len_nxt;
    end
  end

  `WAVHP_ASSERT_HOLDS(a_idx_range, clk, rst_n, idx_r < wavhp_pkg::FMT_FIELDS_LEN)
  `WAVHP_ASSERT_IMPLIES(a_count_live, clk, rst_n, (phase_r == wavhp_pkg::PH_SKIP1_BODY || phase_r == wavhp_pkg::PH_SKIP2_BODY || phase_r == wavhp_pkg::PH_FMT_PAD || phase_r == wavhp_pkg::PH_PAYLOAD), rem_r != 32'd0)
  `WAVHP_ASSERT_NEXT(a_error_sticky, clk, rst_n, (step_en && !start_of_file && phase_r == wavhp_pkg::PH_ERROR), phase_r == wavhp_pkg::PH_ERROR)

endmodule

`default_nettype wire

FILE: hw/rtl/wav_header_stream_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Transaction
// in_chan   sink       one byte of the file stream with its start of file flag
// out_chan  source     status, payload byte and the latched format fields
//
// One transaction is taken per cycle while in_chan.ready is high; a byte's
// result appears in the output register in the cycle after it is accepted.
// The cycle is set by the 32-bit remaining-byte decrement and zero compare.
// A synchronous reset puts the parser at the start of the RIFF header.
// A new input is taken while the output register is empty or being drained.

`include "wav_header_stream_parser_top_macros.svh"

module wav_header_stream_parser_top (
  input  logic          clk,
  input  logic          rst_n,
  wavhp_in_if.sink      in_chan,
  wavhp_out_if.source   out_chan
);

  logic                     accept;
  logic                     out_valid_r;
  wavhp_pkg::wavhp_result_t res_r;
  wavhp_pkg::wavhp_result_t step_res;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  wavhp_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (accept),
    .data_byte    (in_chan.data_byte),
    .start_of_file(in_chan.start_of_file),
    .result       (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= step_res;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = res_r.status;
  assign out_chan.payload_byte   = res_r.payload_byte;
  assign out_chan.last_payload   = res_r.last_payload;
  assign out_chan.channel_count  = res_r.channel_count;
  assign out_chan.rate_hz        = res_r.rate_hz;
  assign out_chan.sample_bits    = res_r.sample_bits;
  assign out_chan.payload_length = res_r.payload_length;

  `WAVHP_ASSERT_NEXT(a_accept_shows, clk, rst_n, accept, out_valid_r)
  `WAVHP_ASSERT_IMPLIES(a_last_is_payload, clk, rst_n, (out_valid_r && res_r.last_payload), res_r.status == wavhp_pkg::ST_PAYLOAD)
  `WAVHP_ASSERT_IMPLIES(a_payload_has_length, clk, rst_n, (out_valid_r && res_r.status == wavhp_pkg::ST_PAYLOAD), res_r.payload_length != 32'd0)

endmodule

`default_nettype wire
